FILE: rtl/gbn_pkg.sv
// shared types and constants for the go-back-n sender window engine
// no dependencies; imported by the controller, datapath and top level
`timescale 1ns / 1ps

package gbn_pkg;

    // chunk size is a power of two so offsets and frame counts reduce to shifts
    localparam int CHUNK_BYTES     = 1024;
    localparam int CHUNK_SHIFT     = $clog2(CHUNK_BYTES);
    localparam int MAX_FRAMES      = 65536;
    localparam int WINDOW_MAX_DEF  = 16;

    localparam int LEN_W     = 27;
    localparam int SEQ_W     = 16;
    localparam int CHUNK_W   = 11;
    localparam int OFF_W     = 26;
    localparam int TOTAL_W   = 32;
    localparam int FRAME_W   = 17;
    localparam int WSIZE_W   = 5;
    localparam int TRIES_W   = 8;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 8;

    localparam logic [LEN_W-1:0] LEN_CAP = LEN_W'(MAX_FRAMES * CHUNK_BYTES);

    localparam logic [1:0] ACT_START   = 2'd0;
    localparam logic [1:0] ACT_ACK     = 2'd1;
    localparam logic [1:0] ACT_TIMEOUT = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_TRIES   = 1'b1;

    localparam logic KIND_DATA     = 1'b0;
    localparam logic KIND_TEARDOWN = 1'b1;

    typedef struct packed {
        logic accept;
        logic burst_init;
        logic load_data;
        logic load_tear;
    } gbn_cmd_t;

    typedef struct packed {
        logic ev_valid;
        logic ev_send;
        logic busy;
        logic done_all;
        logic tries_out;
        logic slot_free;
        logic burst_last;
    } gbn_status_t;

endpackage

FILE: rtl/gbn_ctrl.sv
// sequencing state machine: event accept, settle decision, burst and teardown
// depends on gbn_pkg for the command and status structs
`timescale 1ns / 1ps

module gbn_ctrl
    import gbn_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  gbn_status_t status,
    output gbn_cmd_t    cmd
);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SETTLE = 4'b0010,
        ST_BURST  = 4'b0100,
        ST_TEAR   = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   send_reg;
    logic   send_next;

    assign in_stall = (state_reg != ST_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        send_next      = send_reg;
        cmd.accept     = 1'b0;
        cmd.burst_init = 1'b0;
        cmd.load_data  = 1'b0;
        cmd.load_tear  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                cmd.accept = in_valid;
                if (in_valid && status.ev_valid)
                begin
                    send_next  = status.ev_send;
                    state_next = ST_SETTLE;
                end
            end
            ST_SETTLE:
            begin
                if (status.done_all || status.tries_out)
                begin
                    state_next = ST_TEAR;
                end
                else if (send_reg)
                begin
                    cmd.burst_init = 1'b1;
                    state_next     = ST_BURST;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_BURST:
            begin
                if (status.slot_free)
                begin
                    cmd.load_data = 1'b1;
                    if (status.burst_last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_TEAR:
            begin
                if (status.slot_free)
                begin
                    cmd.load_tear = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            send_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            send_reg  <= send_next;
        end
    end

`ifndef ASSERT_OFF
    a_burst_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_BURST) |-> status.busy)
        else $error("burst running without an open transfer");

    a_tear_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_TEAR && status.slot_free) |=> !status.busy)
        else $error("teardown did not close the transfer");
`endif

endmodule

FILE: rtl/gbn_datapath.sv
// window state, totals, configuration registers and the result register
// depends on gbn_pkg; driven by commands from gbn_ctrl
`timescale 1ns / 1ps

module gbn_datapath
    import gbn_pkg::*;
#(
    parameter int WINDOW_MAX = WINDOW_MAX_DEF
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_write,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [CFG_DAT_W-1:0]        cfg_data,
    input  logic [1:0]                  action,
    input  logic [LEN_W-1:0]            total_length,
    input  logic                        ack_is_ack,
    input  logic signed [FRAME_W-1:0]   ack_seq,
    input  gbn_cmd_t                    cmd,
    output gbn_status_t                 status,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic                        frame_kind,
    output logic [SEQ_W-1:0]            seq_no,
    output logic [CHUNK_W-1:0]          chunk_len,
    output logic [OFF_W-1:0]            byte_offset,
    output logic                        gave_up,
    output logic [TOTAL_W-1:0]          bytes_sent_total,
    output logic [TOTAL_W-1:0]          retrans_total,
    output logic                        last
);

    localparam int WIN_W = $clog2(WINDOW_MAX + 1);

    // configuration
    logic [WSIZE_W-1:0] window_size_reg, window_size_next;
    logic [TRIES_W-1:0] max_tries_reg, max_tries_next;

    // transfer state
    logic                      busy_reg, busy_next;
    logic [FRAME_W-1:0]        window_base_reg, window_base_next;
    logic signed [FRAME_W-1:0] highest_sent_reg, highest_sent_next;
    logic signed [FRAME_W-1:0] highest_acked_reg, highest_acked_next;
    logic [FRAME_W-1:0]        frame_count_reg, frame_count_next;
    logic [LEN_W-1:0]          message_length_reg, message_length_next;
    logic [TRIES_W-1:0]        retry_count_reg, retry_count_next;
    logic [TOTAL_W-1:0]        bytes_issued_reg, bytes_issued_next;
    logic [TOTAL_W-1:0]        retrans_count_reg, retrans_count_next;

    // burst walk
    logic [WIN_W-1:0]   burst_cnt_reg, burst_cnt_next;
    logic [FRAME_W-1:0] seq_reg, seq_next;

    // result register
    logic                 out_valid_reg, out_valid_next;
    logic                 kind_reg, kind_next;
    logic [SEQ_W-1:0]     seq_no_reg, seq_no_next;
    logic [CHUNK_W-1:0]   chunk_reg, chunk_next;
    logic [OFF_W-1:0]     off_reg, off_next;
    logic                 gave_reg, gave_next;
    logic [TOTAL_W-1:0]   bytes_out_reg, bytes_out_next;
    logic [TOTAL_W-1:0]   retrans_out_reg, retrans_out_next;
    logic                 last_reg, last_next;

    logic [WIN_W-1:0]          win_eff;
    logic signed [FRAME_W:0]   hs_ext, ha_ext, fc_m1, outstanding;
    logic [LEN_W-1:0]          len_clamped;
    logic [LEN_W:0]            len_round;
    logic [FRAME_W-1:0]        fc_new;
    logic                      ack_newer;
    logic [TRIES_W-1:0]        retry_inc;
    logic [TOTAL_W:0]          retrans_sum;
    logic [TOTAL_W-1:0]        retrans_sat;
    logic [LEN_W-1:0]          off_full;
    logic [LEN_W-1:0]          remain;
    logic [CHUNK_W-1:0]        chunk_now;
    logic [TOTAL_W:0]          bytes_sum;
    logic [TOTAL_W-1:0]        bytes_sat;
    logic                      slot_free;

    always_comb
    begin
        if (window_size_reg == '0)
        begin
            win_eff = WIN_W'(1);
        end
        else if (32'(window_size_reg) > 32'(WINDOW_MAX))
        begin
            win_eff = WIN_W'(WINDOW_MAX);
        end
        else
        begin
            win_eff = WIN_W'(window_size_reg);
        end
    end

    assign hs_ext = {highest_sent_reg[FRAME_W-1], highest_sent_reg};
    assign ha_ext = {highest_acked_reg[FRAME_W-1], highest_acked_reg};
    assign fc_m1  = $signed({1'b0, frame_count_reg}) - 18'sd1;

    // start: clamp length and round up to whole chunks
    assign len_clamped = (total_length > LEN_CAP) ? LEN_CAP : total_length;
    assign len_round   = {1'b0, len_clamped} + (LEN_W + 1)'(CHUNK_BYTES - 1);
    assign fc_new      = FRAME_W'(len_round >> CHUNK_SHIFT);

    assign ack_newer = (ack_seq > highest_acked_reg);

    // timeout: saturating retry count and retransmission total
    assign retry_inc   = (retry_count_reg == '1) ? retry_count_reg
                                                 : retry_count_reg + TRIES_W'(1);
    assign outstanding = hs_ext - ha_ext;
    assign retrans_sum = {1'b0, retrans_count_reg}
                       + ((outstanding > 0) ? (TOTAL_W + 1)'(outstanding[FRAME_W-1:0])
                                            : '0);
    assign retrans_sat = retrans_sum[TOTAL_W] ? '1 : retrans_sum[TOTAL_W-1:0];

    // burst: offset and length of the chunk at seq_reg
    assign off_full  = LEN_W'(seq_reg) << CHUNK_SHIFT;
    assign remain    = message_length_reg - off_full;
    assign chunk_now = (remain >= LEN_W'(CHUNK_BYTES)) ? CHUNK_W'(CHUNK_BYTES)
                                                       : CHUNK_W'(remain);
    assign bytes_sum = {1'b0, bytes_issued_reg} + (TOTAL_W + 1)'(chunk_now);
    assign bytes_sat = bytes_sum[TOTAL_W] ? '1 : bytes_sum[TOTAL_W-1:0];

    assign slot_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        status.busy       = busy_reg;
        status.done_all   = (ha_ext >= fc_m1);
        status.tries_out  = (retry_count_reg >= max_tries_reg);
        status.slot_free  = slot_free;
        status.burst_last = ((burst_cnt_reg + WIN_W'(1)) == win_eff)
                          || ((18'(seq_reg) + 18'd1) >= 18'(frame_count_reg));
        status.ev_send    = 1'b1;
        case (action)
            ACT_START:
            begin
                status.ev_valid = !busy_reg;
            end
            ACT_ACK:
            begin
                status.ev_valid = busy_reg && ack_is_ack && ack_newer;
                status.ev_send  = (ack_seq == highest_sent_reg);
            end
            ACT_TIMEOUT:
            begin
                status.ev_valid = busy_reg;
            end
            default:
            begin
                status.ev_valid = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        window_size_next    = window_size_reg;
        max_tries_next      = max_tries_reg;
        busy_next           = busy_reg;
        window_base_next    = window_base_reg;
        highest_sent_next   = highest_sent_reg;
        highest_acked_next  = highest_acked_reg;
        frame_count_next    = frame_count_reg;
        message_length_next = message_length_reg;
        retry_count_next    = retry_count_reg;
        bytes_issued_next   = bytes_issued_reg;
        retrans_count_next  = retrans_count_reg;
        burst_cnt_next      = burst_cnt_reg;
        seq_next            = seq_reg;
        out_valid_next      = out_valid_reg;
        kind_next           = kind_reg;
        seq_no_next         = seq_no_reg;
        chunk_next          = chunk_reg;
        off_next            = off_reg;
        gave_next           = gave_reg;
        bytes_out_next      = bytes_out_reg;
        retrans_out_next    = retrans_out_reg;
        last_next           = last_reg;

        if (cfg_write)
        begin
            case (cfg_index)
                REG_WINDOW_SIZE: window_size_next = cfg_data[WSIZE_W-1:0];
                REG_MAX_TRIES:   max_tries_next   = cfg_data[TRIES_W-1:0];
                default:         window_size_next = window_size_reg;
            endcase
        end

        if (cmd.accept && status.ev_valid)
        begin
            case (action)
                ACT_START:
                begin
                    message_length_next = len_clamped;
                    frame_count_next    = fc_new;
                    window_base_next    = '0;
                    highest_sent_next   = '1;
                    highest_acked_next  = '1;
                    retry_count_next    = '0;
                    busy_next           = 1'b1;
                end
                ACT_ACK:
                begin
                    highest_acked_next = ack_seq;
                    window_base_next   = FRAME_W'(ack_seq) + FRAME_W'(1);
                    retry_count_next   = '0;
                end
                ACT_TIMEOUT:
                begin
                    retry_count_next   = retry_inc;
                    retrans_count_next = retrans_sat;
                end
                default:
                begin
                    busy_next = busy_reg;
                end
            endcase
        end

        if (cmd.burst_init)
        begin
            burst_cnt_next = '0;
            seq_next       = window_base_reg;
        end

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        if (cmd.load_data)
        begin
            bytes_issued_next = bytes_sat;
            if ($signed(seq_reg) > highest_sent_reg)
            begin
                highest_sent_next = $signed(seq_reg);
            end
            burst_cnt_next   = burst_cnt_reg + WIN_W'(1);
            seq_next         = seq_reg + FRAME_W'(1);
            out_valid_next   = 1'b1;
            kind_next        = KIND_DATA;
            seq_no_next      = seq_reg[SEQ_W-1:0];
            chunk_next       = chunk_now;
            off_next         = off_full[OFF_W-1:0];
            gave_next        = 1'b0;
            bytes_out_next   = bytes_sat;
            retrans_out_next = retrans_count_reg;
            last_next        = status.burst_last;
        end

        if (cmd.load_tear)
        begin
            busy_next        = 1'b0;
            out_valid_next   = 1'b1;
            kind_next        = KIND_TEARDOWN;
            seq_no_next      = '0;
            chunk_next       = '0;
            off_next         = '0;
            gave_next        = !status.done_all;
            bytes_out_next   = bytes_issued_reg;
            retrans_out_next = retrans_count_reg;
            last_next        = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_size_reg    <= WSIZE_W'(4);
            max_tries_reg      <= TRIES_W'(10);
            busy_reg           <= 1'b0;
            window_base_reg    <= '0;
            highest_sent_reg   <= '1;
            highest_acked_reg  <= '1;
            frame_count_reg    <= '0;
            message_length_reg <= '0;
            retry_count_reg    <= '0;
            bytes_issued_reg   <= '0;
            retrans_count_reg  <= '0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            window_size_reg    <= window_size_next;
            max_tries_reg      <= max_tries_next;
            busy_reg           <= busy_next;
            window_base_reg    <= window_base_next;
            highest_sent_reg   <= highest_sent_next;
            highest_acked_reg  <= highest_acked_next;
            frame_count_reg    <= frame_count_next;
            message_length_reg <= message_length_next;
            retry_count_reg    <= retry_count_next;
            bytes_issued_reg   <= bytes_issued_next;
            retrans_count_reg  <= retrans_count_next;
            out_valid_reg      <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        burst_cnt_reg   <= burst_cnt_next;
        seq_reg         <= seq_next;
        kind_reg        <= kind_next;
        seq_no_reg      <= seq_no_next;
        chunk_reg       <= chunk_next;
        off_reg         <= off_next;
        gave_reg        <= gave_next;
        bytes_out_reg   <= bytes_out_next;
        retrans_out_reg <= retrans_out_next;
        last_reg        <= last_next;
    end

    assign out_valid        = out_valid_reg;
    assign frame_kind       = kind_reg;
    assign seq_no           = seq_no_reg;
    assign chunk_len        = chunk_reg;
    assign byte_offset      = off_reg;
    assign gave_up          = gave_reg;
    assign bytes_sent_total = bytes_out_reg;
    assign retrans_total    = retrans_out_reg;
    assign last             = last_reg;

`ifndef ASSERT_OFF
    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.load_data || cmd.load_tear) |-> slot_free)
        else $error("result register overwritten while a request waits");

    a_sent_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        hs_ext < $signed({1'b0, frame_count_reg}))
        else $error("highest sent frame beyond the message");
`endif

endmodule

FILE: rtl/go_back_n_sender_window_core.sv
// go-back-n sender window engine: one event request in, up to a window of frame requests out
// an event is taken in the idle state and decided in the settle state; any result is registered
// from the burst or teardown state; an acted-upon event gives up to a window size of results, one per
// cycle in a burst while out_stall is low; an ignored event leaves the core in the idle state
// reset (rst_n, asynchronous, active low): idle, no transfer open, totals cleared,
// window size 4, retry limit 10
`timescale 1ns / 1ps

module go_back_n_sender_window_core
    import gbn_pkg::*;
#(
    parameter int WINDOW_MAX = WINDOW_MAX_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_write,
    input  logic [CFG_IDX_W-1:0]      cfg_index,
    input  logic [CFG_DAT_W-1:0]      cfg_data,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [1:0]                action,
    input  logic [LEN_W-1:0]          total_length,
    input  logic                      ack_is_ack,
    input  logic signed [FRAME_W-1:0] ack_seq,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic                      frame_kind,
    output logic [SEQ_W-1:0]          seq_no,
    output logic [CHUNK_W-1:0]        chunk_len,
    output logic [OFF_W-1:0]          byte_offset,
    output logic                      gave_up,
    output logic [TOTAL_W-1:0]        bytes_sent_total,
    output logic [TOTAL_W-1:0]        retrans_total,
    output logic                      last
);

    gbn_cmd_t    cmd;
    gbn_status_t status;

    gbn_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    gbn_datapath #(
        .WINDOW_MAX (WINDOW_MAX)
    ) u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write        (cfg_write),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .action           (action),
        .total_length     (total_length),
        .ack_is_ack       (ack_is_ack),
        .ack_seq          (ack_seq),
        .cmd              (cmd),
        .status           (status),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .frame_kind       (frame_kind),
        .seq_no           (seq_no),
        .chunk_len        (chunk_len),
        .byte_offset      (byte_offset),
        .gave_up          (gave_up),
        .bytes_sent_total (bytes_sent_total),
        .retrans_total    (retrans_total),
        .last             (last)
    );

endmodule

FILE: tb/sv/tb.sv
// testbench for go_back_n_sender_window_core: random and directed events with a cycle-free predictor
// depends on gbn_pkg and the core; results are checked in order against the predicted frame commands
`timescale 1ns / 1ps

module tb;
    import gbn_pkg::*;

    localparam logic [1:0] ACT_UNUSED = 2'd3;
    localparam longint LEN_LIMIT = longint'(MAX_FRAMES) * CHUNK_BYTES;

    typedef struct packed {
        logic        kind;
        logic [15:0] seq;
        logic [10:0] len;
        logic [25:0] off;
        logic        gave;
        logic [31:0] bytes;
        logic [31:0] retrans;
        logic        fin;
    } frame_cmd_t;

    logic clk;
    logic rst_n = 1'b0;
    logic cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DAT_W-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [1:0] action = ACT_START;
    logic [LEN_W-1:0] total_length = '0;
    logic ack_is_ack = 1'b0;
    logic signed [FRAME_W-1:0] ack_seq = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic frame_kind;
    logic [SEQ_W-1:0] seq_no;
    logic [CHUNK_W-1:0] chunk_len;
    logic [OFF_W-1:0] byte_offset;
    logic gave_up;
    logic [TOTAL_W-1:0] bytes_sent_total;
    logic [TOTAL_W-1:0] retrans_total;
    logic last;

    go_back_n_sender_window_core u_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write        (cfg_write),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .action           (action),
        .total_length     (total_length),
        .ack_is_ack       (ack_is_ack),
        .ack_seq          (ack_seq),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .frame_kind       (frame_kind),
        .seq_no           (seq_no),
        .chunk_len        (chunk_len),
        .byte_offset      (byte_offset),
        .gave_up          (gave_up),
        .bytes_sent_total (bytes_sent_total),
        .retrans_total    (retrans_total),
        .last             (last)
    );

    // predictor copy of the sender state
    logic [4:0]  win_reg;
    logic [7:0]  tries_reg;
    bit          xfer_busy;
    int          win_base;
    int          sent_hi;
    int          acked_hi;
    int          n_frames;
    longint      msg_len;
    int          retries;
    logic [31:0] bytes_tot;
    logic [31:0] retrans_tot;

    frame_cmd_t expected_frames[$];
    frame_cmd_t new_frames[$];
    int  mismatches = 0;
    int  taken_items = 0;
    bit  idle_on = 1'b1;
    int  stall_left = 0;
    frame_cmd_t got_cmd;
    frame_cmd_t want_cmd;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #20_000_000;
        $display("Verification failed");
        $finish;
    end

    function automatic logic [31:0] sat_add(logic [31:0] a, longint b);
        longint s;
        s = longint'(a) + b;
        return (s > longint'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    function automatic void push_cmd(logic kind, int seq, int len, longint off, logic gave);
        frame_cmd_t c;
        c.kind    = kind;
        c.seq     = 16'(seq);
        c.len     = 11'(len);
        c.off     = 26'(off);
        c.gave    = gave;
        c.bytes   = bytes_tot;
        c.retrans = retrans_tot;
        c.fin     = 1'b0;
        new_frames.push_back(c);
    endfunction

    function automatic void issue_window();
        int w;
        int seq;
        int hs;
        int chunk;
        longint off;
        w = int'(win_reg);
        if (w == 0)
            w = 1;
        if (w > WINDOW_MAX_DEF)
            w = WINDOW_MAX_DEF;
        for (int c = 0; c < w; c++)
        begin
            seq = win_base + c;
            hs = (seq > sent_hi) ? seq : sent_hi;
            if (hs > n_frames - 1)
                hs = n_frames - 1;
            sent_hi = hs;
            if (seq >= 0 && seq < n_frames)
            begin
                off = longint'(seq) * CHUNK_BYTES;
                chunk = (msg_len - off >= CHUNK_BYTES) ? CHUNK_BYTES
                                                       : int'(msg_len % CHUNK_BYTES);
                bytes_tot = sat_add(bytes_tot, longint'(chunk));
                push_cmd(KIND_DATA, seq, chunk, off, 1'b0);
            end
        end
    endfunction

    // teardown on completion or give-up, otherwise optionally a window burst
    function automatic void settle_transfer(bit send);
        if (acked_hi >= n_frames - 1)
        begin
            xfer_busy = 1'b0;
            push_cmd(KIND_TEARDOWN, 0, 0, 0, 1'b0);
        end
        else if (retries >= tries_reg)
        begin
            xfer_busy = 1'b0;
            push_cmd(KIND_TEARDOWN, 0, 0, 0, 1'b1);
        end
        else if (send)
            issue_window();
    endfunction

    // returns 1 when the event was acted upon rather than ignored
    function automatic bit predict_event(logic [1:0] act, logic [26:0] len_in, logic is_ack,
                                         logic [16:0] seq_raw);
        longint len;
        int ackv;
        new_frames.delete();
        if (act == ACT_START)
        begin
            if (xfer_busy)
                return 1'b0;
            len = longint'(len_in);
            if (len > LEN_LIMIT)
                len = LEN_LIMIT;
            msg_len = len;
            n_frames = int'((len + CHUNK_BYTES - 1) / CHUNK_BYTES);
            win_base = 0;
            sent_hi = -1;
            acked_hi = -1;
            retries = 0;
            xfer_busy = 1'b1;
            settle_transfer(1'b1);
        end
        else if (act == ACT_ACK)
        begin
            ackv = int'($signed(seq_raw));
            if (!xfer_busy || !is_ack || ackv <= acked_hi)
                return 1'b0;
            acked_hi = ackv;
            win_base = ackv + 1;
            retries = 0;
            settle_transfer(acked_hi == sent_hi);
        end
        else if (act == ACT_TIMEOUT)
        begin
            if (!xfer_busy)
                return 1'b0;
            if (retries < 255)
                retries++;
            if (sent_hi - acked_hi > 0)
                retrans_tot = sat_add(retrans_tot, longint'(sent_hi - acked_hi));
            settle_transfer(1'b1);
        end
        else
            return 1'b0;
        if (new_frames.size() > 0)
            new_frames[new_frames.size()-1].fin = 1'b1;
        foreach (new_frames[i])
            expected_frames.push_back(new_frames[i]);
        return 1'b1;
    endfunction

    task automatic send_event(logic [1:0] act, logic [26:0] len, logic is_ack, logic [16:0] seq);
        if (idle_on && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        in_valid     <= 1'b1;
        action       <= act;
        total_length <= len;
        ack_is_ack   <= is_ack;
        ack_seq      <= seq;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        void'(predict_event(act, len, is_ack, seq));
        taken_items++;
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (expected_frames.size() != 0)
            @(posedge clk);
        // events with no result still pass through the settle state, so wait on past an empty queue
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
        wait_idle();
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_write <= 1'b0;
        if (idx == REG_WINDOW_SIZE)
            win_reg = val[4:0];
        else
            tries_reg = val;
    endtask

    // result checker and receiver stall bursts
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            got_cmd = '{frame_kind, seq_no, chunk_len, byte_offset, gave_up,
                        bytes_sent_total, retrans_total, last};
            if (expected_frames.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected frame command: kind %0d seq %0d len %0d", frame_kind,
                             seq_no, chunk_len);
            end
            else
            begin
                want_cmd = expected_frames.pop_front();
                if (got_cmd.kind !== want_cmd.kind || got_cmd.seq !== want_cmd.seq ||
                    got_cmd.len !== want_cmd.len || got_cmd.off !== want_cmd.off ||
                    got_cmd.gave !== want_cmd.gave || got_cmd.bytes !== want_cmd.bytes ||
                    got_cmd.retrans !== want_cmd.retrans || got_cmd.fin !== want_cmd.fin)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $write("mismatch exp: kind %0d seq %0d len %0d off %0d ",
                               want_cmd.kind, want_cmd.seq, want_cmd.len, want_cmd.off);
                        $display("gave %0d bytes %0d retx %0d last %0d",
                                 want_cmd.gave, want_cmd.bytes, want_cmd.retrans, want_cmd.fin);
                        $write("         got: kind %0d seq %0d len %0d off %0d ",
                               got_cmd.kind, got_cmd.seq, got_cmd.len, got_cmd.off);
                        $display("gave %0d bytes %0d retx %0d last %0d",
                                 got_cmd.gave, got_cmd.bytes, got_cmd.retrans, got_cmd.fin);
                    end
                end
            end
        end
        if (stall_left > 0)
        begin
            stall_left--;
            out_stall <= 1'b1;
        end
        else if (idle_on && $urandom_range(0, 5) == 0)
        begin
            stall_left = $urandom_range(1, 10) - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    task automatic test_ignored_and_empty();
        send_event(ACT_TIMEOUT, 0, 1'b0, 0);
        send_event(ACT_ACK, 0, 1'b1, 0);
        send_event(ACT_UNUSED, 27'h7FF_FFFF, 1'b1, 17'h1_FFFF);
        send_event(ACT_START, 0, 1'b0, 0);
    endtask

    task automatic test_clamped_transfer();
        // over-long length is clamped, then acks and timeouts walk the window
        send_event(ACT_START, 27'h7FF_FFFF, 1'b0, 0);
        send_event(ACT_START, 5, 1'b0, 0);
        send_event(ACT_ACK, 0, 1'b0, 2);
        send_event(ACT_ACK, 0, 1'b1, 17'h1_FFFF);
        send_event(ACT_ACK, 0, 1'b1, 17'h1_0000);
        send_event(ACT_ACK, 0, 1'b1, 1);
        send_event(ACT_ACK, 0, 1'b1, 3);
        send_event(ACT_TIMEOUT, 0, 1'b0, 0);
        send_event(ACT_ACK, 0, 1'b1, 100);
        send_event(ACT_TIMEOUT, 0, 1'b0, 0);
        send_event(ACT_ACK, 0, 1'b1, 65535);
    endtask

    task automatic test_short_chunks();
        send_event(ACT_START, 1, 1'b0, 0);
        send_event(ACT_ACK, 0, 1'b1, 0);
        send_event(ACT_START, 1025, 1'b0, 0);
        send_event(ACT_TIMEOUT, 0, 1'b0, 0);
        send_event(ACT_ACK, 0, 1'b1, 1);
        send_event(ACT_START, 27'(LEN_LIMIT), 1'b0, 0);
        send_event(ACT_ACK, 0, 1'b1, 65535);
    endtask

    task automatic test_config_extremes();
        write_reg(REG_MAX_TRIES, 8'd0);
        send_event(ACT_START, 3000, 1'b0, 0);
        // window field wraps to zero, which the core treats as one
        write_reg(REG_WINDOW_SIZE, 8'h20);
        write_reg(REG_MAX_TRIES, 8'd1);
        send_event(ACT_START, 5000, 1'b0, 0);
        send_event(ACT_TIMEOUT, 0, 1'b0, 0);
        write_reg(REG_WINDOW_SIZE, 8'hFF);
        write_reg(REG_MAX_TRIES, 8'hFF);
        send_event(ACT_START, 20000, 1'b0, 0);
        send_event(ACT_ACK, 0, 1'b1, 15);
        send_event(ACT_ACK, 0, 1'b1, 19);
    endtask

    task automatic run_transfer();
        int r;
        int lo;
        int hi;
        int seq;
        int events;
        if ($urandom_range(0, 9) == 0)
            send_event(ACT_START, 27'($urandom_range(0, 27'h7FF_FFFF)), 1'b0, 0);
        else
            send_event(ACT_START, 27'($urandom_range(0, 12000)), 1'b0, 0);
        events = 0;
        while (xfer_busy && events < 25)
        begin
            r = $urandom_range(0, 99);
            if (r < 55)
            begin
                lo = acked_hi + 1;
                hi = (sent_hi > lo) ? sent_hi : lo;
                if ($urandom_range(0, 9) == 0)
                    seq = hi + $urandom_range(1, 40);
                else if ($urandom_range(0, 2) == 0)
                    seq = hi;
                else
                    seq = $urandom_range(lo, hi);
                if (seq > 65535)
                    seq = 65535;
                send_event(ACT_ACK, 27'($urandom), 1'b1, 17'(seq));
            end
            else if (r < 80)
                send_event(ACT_TIMEOUT, 27'($urandom), 1'($urandom), 17'($urandom));
            else if (r < 85)
                send_event(ACT_ACK, 0, 1'b0, 17'($urandom_range(0, 17'h1_FFFF)));
            else if (r < 90)
                send_event(ACT_ACK, 0, 1'b1, 17'(acked_hi - $urandom_range(0, 3)));
            else if (r < 94)
                send_event(ACT_START, 27'($urandom), 1'b0, 0);
            else if (r < 97)
                send_event(ACT_UNUSED, 27'($urandom), 1'($urandom), 17'($urandom));
            else
                send_event(ACT_ACK, 0, 1'b1, 17'($urandom_range(0, 17'h1_FFFF)));
            events++;
        end
        // close a long transfer with an ack of its last frame
        if (xfer_busy)
            send_event(ACT_ACK, 0, 1'b1, 17'(n_frames - 1));
    endtask

    task automatic test_random_traffic();
        int stop;
        for (int phase = 0; phase < 6; phase++)
        begin
            if (phase == 2)
                write_reg(REG_WINDOW_SIZE, 8'd1);
            else if (phase == 3)
                write_reg(REG_WINDOW_SIZE, 8'd16);
            else
                write_reg(REG_WINDOW_SIZE, 8'($urandom_range(0, 255)));
            if (phase == 4)
                write_reg(REG_MAX_TRIES, 8'd255);
            else if ($urandom_range(0, 15) == 0)
                write_reg(REG_MAX_TRIES, 8'd0);
            else
                write_reg(REG_MAX_TRIES, 8'($urandom_range(1, 8)));
            idle_on = (phase < 5);
            stop = taken_items + 55;
            while (taken_items < stop)
                run_transfer();
        end
    endtask

    initial
    begin
        int drain;
        win_reg = 5'd4;
        tries_reg = 8'd10;
        xfer_busy = 1'b0;
        win_base = 0;
        sent_hi = -1;
        acked_hi = -1;
        n_frames = 0;
        msg_len = 0;
        retries = 0;
        bytes_tot = '0;
        retrans_tot = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_ignored_and_empty();
        test_clamped_transfer();
        test_short_chunks();
        test_config_extremes();
        test_random_traffic();

        in_valid <= 1'b0;
        drain = 0;
        while (expected_frames.size() != 0 && drain < 5000)
        begin
            @(posedge clk);
            drain++;
        end
        repeat (20) @(posedge clk);
        if (expected_frames.size() != 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0d frame commands never arrived", expected_frames.size());
        end
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/gbn_pkg.sv
rtl/gbn_ctrl.sv
rtl/gbn_datapath.sv
rtl/go_back_n_sender_window_core.sv
tb/sv/tb.sv
